@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl of the handheld bus memory map
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define HBMM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// clocked implication, switched off while reset is high
`define HBMM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  `HBMM_ASSERT(lbl, clk, rst, (ante) |-> (cons))

`endif

@@ hw/rtl/hbmm_pkg.sv @@
// types and constants of the handheld bus memory map
// no dependencies; used by hbmm_decode and handheld_bus_memory_map
`timescale 1ns / 1ps

package hbmm_pkg;

  localparam int STORE_AW    = 15;
  localparam int STORE_DEPTH = 32768;
  localparam int BYTE_W      = 8;

  typedef logic [STORE_AW-1:0] store_addr_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [15:0]         bus_addr_t;

  // address map
  localparam bus_addr_t ROM_LIMIT   = 16'h8000;
  localparam bus_addr_t WRAM_LO     = 16'hC000;
  localparam bus_addr_t WRAM_HI     = 16'hDDFF;
  localparam bus_addr_t COPY_LIMIT  = 16'hC0A0;
  localparam bus_addr_t ECHO_LO     = 16'hE000;
  localparam bus_addr_t ECHO_HI     = 16'hFDFF;
  localparam bus_addr_t KEY_ADDR    = 16'hFF00;
  localparam bus_addr_t ECHO_OFFSET = 16'h2000;
  localparam bus_addr_t COPY_OFFSET = 16'h3E00;

  // key column register
  localparam byte_t KEY_MASK    = 8'h30;
  localparam byte_t KEY_SEL_DIR = 8'h10;
  localparam byte_t KEY_SEL_BTN = 8'h20;

  // slots of one byte access
  localparam logic [1:0] STEP_PRIMARY = 2'd0;
  localparam logic [1:0] STEP_MIRROR  = 2'd1;
  localparam logic [1:0] STEP_COPY    = 2'd2;

  // read source
  localparam logic [1:0] SRC_ROM = 2'd0;
  localparam logic [1:0] SRC_RAM = 2'd1;
  localparam logic [1:0] SRC_KEY = 2'd2;

  typedef struct packed {
    logic        rom_we;
    logic        ram_we;
    logic        key_we;
    store_addr_t ram_addr;
    logic [1:0]  src;
  } decode_t;

endpackage

@@ hw/rtl/hbmm_ram.sv @@
// generic single-port synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hbmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/hbmm_decode.sv @@
// address decoder: maps one byte access and its slot to memory strobes
// depends on hbmm_pkg
`timescale 1ns / 1ps

module hbmm_decode (
  input  logic               op,
  input  logic [1:0]         step,
  input  hbmm_pkg::bus_addr_t byte_addr,
  output hbmm_pkg::decode_t  dec
);
  import hbmm_pkg::*;

  logic      in_rom, in_wram, in_echo, in_copy, is_key;
  bus_addr_t up_addr, down_addr, copy_addr;

  assign in_rom    = byte_addr < ROM_LIMIT;
  assign in_wram   = (byte_addr >= WRAM_LO) && (byte_addr <= WRAM_HI);
  assign in_echo   = (byte_addr >= ECHO_LO) && (byte_addr <= ECHO_HI);
  assign in_copy   = in_wram && (byte_addr < COPY_LIMIT);
  assign is_key    = byte_addr == KEY_ADDR;
  assign up_addr   = byte_addr + ECHO_OFFSET;
  assign down_addr = byte_addr - ECHO_OFFSET;
  assign copy_addr = byte_addr + COPY_OFFSET;

  always_comb begin
    dec.rom_we   = 1'b0;
    dec.ram_we   = 1'b0;
    dec.key_we   = 1'b0;
    dec.ram_addr = byte_addr[STORE_AW-1:0];
    dec.src      = SRC_RAM;
    if (op) begin
      case (step)
        STEP_PRIMARY: begin
          dec.rom_we = in_rom;
          dec.key_we = is_key;
          dec.ram_we = !in_rom && !is_key;
        end
        STEP_MIRROR: begin
          // work ram goes up to the echo, echo goes down to work ram
          dec.ram_we   = in_wram || in_echo;
          dec.ram_addr = in_wram ? up_addr[STORE_AW-1:0] : down_addr[STORE_AW-1:0];
        end
        STEP_COPY: begin
          dec.ram_we   = in_copy;
          dec.ram_addr = copy_addr[STORE_AW-1:0];
        end
        default: begin
          dec.ram_we = 1'b0;
        end
      endcase
    end else begin
      if (in_rom) begin
        dec.src = SRC_ROM;
      end else if (is_key) begin
        dec.src = SRC_KEY;
      end else if (in_echo) begin
        dec.ram_addr = down_addr[STORE_AW-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/handheld_bus_memory_map.sv @@
// top level of the handheld bus memory map: sequencer, key register, output register
// depends on hbmm_pkg, hbmm_decode, hbmm_ram and assert_macros.svh
// sequence: a request is accepted in idle, runs its byte slots in busy, then waits in done
// until the output register takes the result; no new request is taken before then, and
// each byte takes three slots (primary, mirror, copy) on the single port of the ram array
// reset: ram cleared by a pass over all 32768 addresses, inputs stalled until it ends
// rom array has no reset and holds nothing useful until written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module handheld_bus_memory_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic                wide,
  input  hbmm_pkg::bus_addr_t address,
  input  logic [15:0]         write_data,
  input  hbmm_pkg::byte_t     keys_direction,
  input  hbmm_pkg::byte_t     keys_buttons,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         read_data
);
  import hbmm_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  step;
  logic        byte_sel;
  store_addr_t clear_cnt;
  byte_t       key_column;

  // captured request
  logic        op_q, wide_q;
  bus_addr_t   addr_q;
  logic [15:0] wdata_q;
  byte_t       kd_q, kb_q;
  logic [15:0] result;

  logic        busy, clearing, accept, out_load;
  bus_addr_t   byte_addr;
  byte_t       byte_wdata, rd_byte, key_byte;
  decode_t     dec;

  logic        rom_we, ram_we;
  store_addr_t ram_addr;
  byte_t       ram_wdata, rom_rdata, ram_rdata;

  assign busy     = state == ST_BUSY;
  assign clearing = state == ST_CLEAR;
  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  // second byte of a word wraps at the top of the map
  assign byte_addr  = byte_sel ? addr_q + 16'd1 : addr_q;
  assign byte_wdata = byte_sel ? wdata_q[15:8] : wdata_q[7:0];

  hbmm_decode u_decode (
    .op        (op_q),
    .step      (step),
    .byte_addr (byte_addr),
    .dec       (dec)
  );

  // memory ports, the clearing pass owns the ram port while it runs
  assign rom_we    = busy && dec.rom_we;
  assign ram_we    = clearing || (busy && dec.ram_we);
  assign ram_addr  = clearing ? clear_cnt : dec.ram_addr;
  assign ram_wdata = clearing ? '0 : byte_wdata;

  hbmm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .addr  (byte_addr[STORE_AW-1:0]),
    .wdata (byte_wdata),
    .rdata (rom_rdata)
  );

  hbmm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // key column read back
  always_comb begin
    if (key_column == KEY_SEL_DIR) begin
      key_byte = kd_q;
    end else if (key_column == KEY_SEL_BTN) begin
      key_byte = kb_q;
    end else begin
      key_byte = '0;
    end
  end

  always_comb begin
    case (dec.src)
      SRC_ROM: rd_byte = rom_rdata;
      SRC_RAM: rd_byte = ram_rdata;
      SRC_KEY: rd_byte = key_byte;
      default: rd_byte = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      step       <= STEP_PRIMARY;
      byte_sel   <= 1'b0;
      clear_cnt  <= '0;
      key_column <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clear_cnt <= clear_cnt + store_addr_t'(1);
          if (&clear_cnt) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_BUSY;
            step     <= STEP_PRIMARY;
            byte_sel <= 1'b0;
          end
        end
        ST_BUSY: begin
          if (dec.key_we) begin
            key_column <= byte_wdata & KEY_MASK;
          end
          if (step == STEP_COPY) begin
            step <= STEP_PRIMARY;
            // word requests run the three slots again for the upper byte
            if (!byte_sel && wide_q) begin
              byte_sel <= 1'b1;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            step <= step + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      wide_q  <= wide;
      addr_q  <= address;
      wdata_q <= write_data;
      kd_q    <= keys_direction;
      kb_q    <= keys_buttons;
      result  <= '0;
    end else if (busy && !op_q && step == STEP_MIRROR) begin
      // read data of the primary slot is registered and is captured in the mirror slot
      if (byte_sel) begin
        result[15:8] <= rd_byte;
      end else begin
        result[7:0] <= rd_byte;
      end
    end
    if (out_load) begin
      read_data <= result;
    end
  end

  `HBMM_ASSERT_IMP(a_clear_no_out, clk, rst, state == ST_CLEAR, !out_valid)
  `HBMM_ASSERT_IMP(a_read_no_write, clk, rst, busy && !op_q,
                   !(dec.rom_we || dec.ram_we || dec.key_we))
  `HBMM_ASSERT_IMP(a_upper_only_wide, clk, rst, busy && byte_sel, wide_q)
  `HBMM_ASSERT(a_out_from_done, clk, rst, $rose(out_valid) |-> $past(state) == ST_DONE)

endmodule
